// ----- rtl/ppja_pkg.sv -----
`default_nettype none

package ppja_pkg;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_ADAPTER_TYPE = 1'b0,
        REG_SUPERIO_MODE = 1'b1
    } reg_index_t;

    // adapter kinds
    typedef enum logic [1:0] {
        ADAPTER_NONE   = 2'd0,
        ADAPTER_SHIFT  = 2'd1,
        ADAPTER_MATRIX = 2'd2,
        ADAPTER_UNUSED = 2'd3
    } adapter_t;

    // item kinds
    typedef enum logic [0:0] {
        OP_DATA_WRITE  = 1'b0,
        OP_STATUS_READ = 1'b1
    } op_t;

    localparam int unsigned WORD_W = 12;

    localparam logic signed [15:0] AXIS_HIGH = 16'sd16383;
    localparam logic signed [15:0] AXIS_LOW  = -16'sd16383;

    localparam logic [7:0] STATUS_BASE = 8'h3f;
    localparam logic [7:0] STATUS_BUSY = 8'h80;
    localparam logic [7:0] STATUS_ACK  = 8'h40;
    localparam logic [7:0] STATUS_IRQ  = 8'h04;

    // one result item
    typedef struct packed {
        logic [7:0] read_data;
        logic       busy_irq_raise;
        logic       busy_irq_clear;
        logic       ack_irq_raise;
        logic       ack_irq_clear;
        logic       latch_irq_raise;
    } result_t;

    // 12-bit word latched from one pad
    function automatic logic [WORD_W-1:0] make_word(
        input logic signed [15:0] x,
        input logic signed [15:0] y,
        input logic        [7:0]  b
    );
        logic [WORD_W-1:0] w;
        w     = '0;
        w[0]  = b[1];
        w[1]  = b[3];
        w[2]  = b[6];
        w[3]  = b[7];
        w[4]  = (y < AXIS_LOW);
        w[5]  = (y > AXIS_HIGH);
        w[6]  = (x < AXIS_LOW);
        w[7]  = (x > AXIS_HIGH);
        w[8]  = b[0];
        w[9]  = b[2];
        w[10] = b[4];
        w[11] = b[5];
        return w;
    endfunction

    // matrix adapter: a low select bit enables its source
    function automatic logic matrix_pad(
        input logic        [7:0]  sel,
        input logic signed [15:0] x,
        input logic signed [15:0] y,
        input logic        [7:0]  b
    );
        logic hit;
        hit = (!sel[0] && (y < AXIS_LOW))
            | (!sel[1] && (y > AXIS_HIGH))
            | (!sel[2] && (x < AXIS_LOW))
            | (!sel[3] && (x > AXIS_HIGH))
            | (!sel[4] && b[0])
            | (!sel[5])
            | (!sel[6] && b[1]);
        return hit;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/parallel_port_joypad_adapter_core.sv -----
`default_nettype none

// channel  | handshake            | payload
// ---------+----------------------+-------------------------------------------
// input    | s_valid / s_ready    | s_mode, s_write_data, pad0 and pad1 fields
// result   | m_valid / m_ready    | m_read_data, five interrupt request bits
// config   | cfg_we (no wait)     | cfg_index, cfg_data
//
// one item per cycle: the result is computed from the transferred item and the
// line state in one pass and is registered into the result register.
// s_ready is low only while a result waits and m_ready is low.
// aresetn (synchronous, active low) clears the configuration, the line state and the result valid.
// configuration writes take effect at the next edge.

module parallel_port_joypad_adapter_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [1:0]          cfg_data,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_mode,
    input  wire logic [7:0]          s_write_data,
    input  wire logic signed [15:0]  s_pad0_x,
    input  wire logic signed [15:0]  s_pad0_y,
    input  wire logic [7:0]          s_pad0_buttons,
    input  wire logic signed [15:0]  s_pad1_x,
    input  wire logic signed [15:0]  s_pad1_y,
    input  wire logic [7:0]          s_pad1_buttons,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_read_data,
    output logic                     m_busy_irq_raise,
    output logic                     m_busy_irq_clear,
    output logic                     m_ack_irq_raise,
    output logic                     m_ack_irq_clear,
    output logic                     m_latch_irq_raise
);
    import ppja_pkg::*;

    adapter_t           adapter_type_reg;
    logic               superio_mode_reg;

    logic               prev_reset_line_reg, prev_reset_line_next;
    logic               prev_clock_line_reg, prev_clock_line_next;
    logic [WORD_W-1:0]  word0_reg, word0_next;
    logic [WORD_W-1:0]  word1_reg, word1_next;
    logic               busy_flag_reg, busy_flag_next;
    logic               ack_flag_reg, ack_flag_next;
    logic               irq_pending_reg, irq_pending_next;

    logic               m_valid_reg, m_valid_next;
    result_t            result_reg, result_next;

    logic               in_xfer;
    logic               drive_lines;
    logic               busy_line;
    logic               ack_line;
    logic               ack_edge;
    logic [WORD_W-1:0]  latched0;
    logic [WORD_W-1:0]  latched1;
    logic [7:0]         status;

    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adapter_type_reg <= ADAPTER_NONE;
            superio_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_ADAPTER_TYPE: adapter_type_reg <= adapter_t'(cfg_data);
                REG_SUPERIO_MODE: superio_mode_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // one-pass item evaluation
    always_comb begin
        prev_reset_line_next = prev_reset_line_reg;
        prev_clock_line_next = prev_clock_line_reg;
        word0_next           = word0_reg;
        word1_next           = word1_reg;
        busy_flag_next       = busy_flag_reg;
        ack_flag_next        = ack_flag_reg;
        irq_pending_next     = irq_pending_reg;
        result_next          = '0;
        drive_lines          = 1'b0;
        busy_line            = 1'b0;
        ack_line             = 1'b0;
        latched0             = word0_reg;
        latched1             = word1_reg;
        status               = STATUS_BASE;

        if (s_mode == OP_STATUS_READ) begin
            // status byte, read clears the pending flag
            if (busy_flag_reg) status = status | STATUS_BUSY;
            if (ack_flag_reg) status = status | STATUS_ACK;
            if (irq_pending_reg) status = status & ~STATUS_IRQ;
            irq_pending_next      = 1'b0;
            result_next.read_data = status;
        end else begin
            case (adapter_type_reg)
                ADAPTER_SHIFT: begin
                    // latch on falling bit 1, then shift on falling bit 2
                    if (!s_write_data[1] && prev_reset_line_reg) begin
                        latched0 = make_word(s_pad0_x, s_pad0_y, s_pad0_buttons);
                        latched1 = make_word(s_pad1_x, s_pad1_y, s_pad1_buttons);
                    end
                    word0_next = latched0;
                    word1_next = latched1;
                    if (!s_write_data[2] && prev_clock_line_reg) begin
                        drive_lines = 1'b1;
                        busy_line   = !latched0[0];
                        ack_line    = latched1[0];
                        word0_next  = {1'b0, latched0[WORD_W-1:1]};
                        word1_next  = {1'b0, latched1[WORD_W-1:1]};
                    end
                    prev_reset_line_next = s_write_data[1];
                    prev_clock_line_next = s_write_data[2];
                end
                ADAPTER_MATRIX: begin
                    drive_lines = 1'b1;
                    busy_line   = matrix_pad(s_write_data, s_pad0_x, s_pad0_y,
                                             s_pad0_buttons);
                    ack_line    = !matrix_pad(s_write_data, s_pad1_x, s_pad1_y,
                                              s_pad1_buttons);
                end
                default: ;
            endcase
        end

        // interrupt requests from the driven lines
        ack_edge = ack_line && !ack_flag_reg;
        if (drive_lines) begin
            busy_flag_next = busy_line;
            ack_flag_next  = ack_line;
            if (!superio_mode_reg) begin
                result_next.busy_irq_raise = busy_line;
                result_next.busy_irq_clear = !busy_line;
                result_next.ack_irq_raise  = ack_edge;
                result_next.ack_irq_clear  = !ack_edge;
            end else begin
                irq_pending_next            = 1'b1;
                result_next.latch_irq_raise = ack_edge;
            end
        end
    end

    // line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reset_line_reg <= 1'b0;
            prev_clock_line_reg <= 1'b0;
            word0_reg           <= '0;
            word1_reg           <= '0;
            busy_flag_reg       <= 1'b0;
            ack_flag_reg        <= 1'b0;
            irq_pending_reg     <= 1'b0;
        end else if (in_xfer) begin
            prev_reset_line_reg <= prev_reset_line_next;
            prev_clock_line_reg <= prev_clock_line_next;
            word0_reg           <= word0_next;
            word1_reg           <= word1_next;
            busy_flag_reg       <= busy_flag_next;
            ack_flag_reg        <= ack_flag_next;
            irq_pending_reg     <= irq_pending_next;
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_xfer) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_read_data       = result_reg.read_data;
    assign m_busy_irq_raise  = result_reg.busy_irq_raise;
    assign m_busy_irq_clear  = result_reg.busy_irq_clear;
    assign m_ack_irq_raise   = result_reg.ack_irq_raise;
    assign m_ack_irq_clear   = result_reg.ack_irq_clear;
    assign m_latch_irq_raise = result_reg.latch_irq_raise;

`ifndef NO_ASSERTIONS
    // busy raise and clear are exclusive
    a_busy_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_busy_irq_raise && m_busy_irq_clear))
        else $error("busy raise and clear together");

    // ack raise and clear are exclusive
    a_ack_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_ack_irq_raise && m_ack_irq_clear))
        else $error("ack raise and clear together");

    // latch interrupt only in super-I/O handling, never with busy or ack requests
    a_latch_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_latch_irq_raise) |-> !(m_ack_irq_raise || m_ack_irq_clear
            || m_busy_irq_raise || m_busy_irq_clear))
        else $error("latch interrupt mixed with line requests");

    // a status read result carries no requests
    a_read_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_data != 8'h00)) |-> !(m_busy_irq_raise
            || m_busy_irq_clear || m_ack_irq_raise || m_ack_irq_clear
            || m_latch_irq_raise))
        else $error("requests on a status read");

    // a status read clears the pending flag
    a_read_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_xfer && (s_mode == OP_STATUS_READ)) |=> !irq_pending_reg)
        else $error("pending flag survives a status read");
`endif

endmodule

`default_nettype wire

// ----- verif/ppja_port_monitor.sv -----
module ppja_port_monitor (
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_we,
    input  wire logic [0:0]          cfg_index,
    input  wire logic [1:0]          cfg_data,

    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire logic                s_mode,
    input  wire logic [7:0]          s_write_data,
    input  wire logic signed [15:0]  s_pad0_x,
    input  wire logic signed [15:0]  s_pad0_y,
    input  wire logic [7:0]          s_pad0_buttons,
    input  wire logic signed [15:0]  s_pad1_x,
    input  wire logic signed [15:0]  s_pad1_y,
    input  wire logic [7:0]          s_pad1_buttons,

    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire logic [7:0]          m_read_data,
    input  wire logic                m_busy_irq_raise,
    input  wire logic                m_busy_irq_clear,
    input  wire logic                m_ack_irq_raise,
    input  wire logic                m_ack_irq_clear,
    input  wire logic                m_latch_irq_raise,

    output int unsigned              mismatch_count,
    output int unsigned              replies_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import ppja_pkg::*;

    // shadow copy of the port registers and line state
    adapter_t          adapter_sel;
    logic              superio_sel;
    logic              latch_line_q;
    logic              clock_line_q;
    logic [WORD_W-1:0] pad_word [2];
    logic              busy_line;
    logic              ack_line;
    logic              latch_pending;
    result_t           port_replies_q [$];

    // {x high, x low, y high, y low}
    function automatic logic [3:0] axis_hits(
        input logic signed [15:0] x,
        input logic signed [15:0] y
    );
        return {x > AXIS_HIGH, x < AXIS_LOW, y > AXIS_HIGH, y < AXIS_LOW};
    endfunction

    // word captured on the latch edge, shifted out lsb first
    function automatic logic [WORD_W-1:0] pad_snapshot(
        input logic signed [15:0] x,
        input logic signed [15:0] y,
        input logic        [7:0]  b
    );
        return {b[5], b[4], b[2], b[0], axis_hits(x, y), b[7], b[6], b[3], b[1]};
    endfunction

    // matrix adapter: any enabled source that is active pulls the pad result
    function automatic logic matrix_select(
        input logic        [7:0]  sel,
        input logic signed [15:0] x,
        input logic signed [15:0] y,
        input logic        [7:0]  b
    );
        logic [6:0] sources;
        sources = {b[1], 1'b1, b[0], axis_hits(x, y)};
        return |(~sel[6:0] & sources);
    endfunction

    // busy line: level-driven requests, silent in super-I/O mode
    function automatic result_t busy_request(input result_t r, input logic line);
        if (!superio_sel) begin
            if (line) r.busy_irq_raise = 1'b1;
            else r.busy_irq_clear = 1'b1;
        end
        busy_line = line;
        return r;
    endfunction

    // ack line: rising edge raises, super-I/O uses the latch interrupt and pending flag
    function automatic result_t ack_request(input result_t r, input logic line);
        logic rising;
        rising = line && !ack_line;
        if (!superio_sel) begin
            if (rising) r.ack_irq_raise = 1'b1;
            else r.ack_irq_clear = 1'b1;
        end else begin
            latch_pending = 1'b1;
            if (rising) r.latch_irq_raise = 1'b1;
        end
        ack_line = line;
        return r;
    endfunction

    // one port access: status read or data write
    function automatic result_t service_port_access(
        input op_t                op,
        input logic        [7:0]  data,
        input logic signed [15:0] x0,
        input logic signed [15:0] y0,
        input logic        [7:0]  b0,
        input logic signed [15:0] x1,
        input logic signed [15:0] y1,
        input logic        [7:0]  b1
    );
        result_t reply;
        reply = '0;
        if (op == OP_STATUS_READ) begin
            reply.read_data = STATUS_BASE;
            if (busy_line) reply.read_data |= STATUS_BUSY;
            if (ack_line) reply.read_data |= STATUS_ACK;
            if (latch_pending) reply.read_data &= ~STATUS_IRQ;
            latch_pending = 1'b0;
        end else if (adapter_sel == ADAPTER_SHIFT) begin
            // latch first, then clock, on the same write
            if (!data[1] && latch_line_q) begin
                pad_word[0] = pad_snapshot(x0, y0, b0);
                pad_word[1] = pad_snapshot(x1, y1, b1);
            end
            if (!data[2] && clock_line_q) begin
                reply = busy_request(reply, !pad_word[0][0]);
                reply = ack_request(reply, pad_word[1][0]);
                pad_word[0] = pad_word[0] >> 1;
                pad_word[1] = pad_word[1] >> 1;
            end
            latch_line_q = data[1];
            clock_line_q = data[2];
        end else if (adapter_sel == ADAPTER_MATRIX) begin
            reply = busy_request(reply, matrix_select(data, x0, y0, b0));
            reply = ack_request(reply, !matrix_select(data, x1, y1, b1));
        end
        return reply;
    endfunction

    // watch both channels and the register port at each edge
    always @(posedge aclk) begin : watch_ports
        result_t seen;
        result_t want;
        if (!aresetn) begin
            adapter_sel    = ADAPTER_NONE;
            superio_sel    = 1'b0;
            latch_line_q   = 1'b0;
            clock_line_q   = 1'b0;
            pad_word[0]    = '0;
            pad_word[1]    = '0;
            busy_line      = 1'b0;
            ack_line       = 1'b0;
            latch_pending  = 1'b0;
            port_replies_q.delete();
            mismatch_count = 0;
            replies_due   <= 0;
        end else begin
            // result transfer against the oldest predicted reply
            if (m_valid && m_ready) begin
                seen = {m_read_data, m_busy_irq_raise, m_busy_irq_clear,
                        m_ack_irq_raise, m_ack_irq_clear, m_latch_irq_raise};
                if (port_replies_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result transfer with none predicted: %02h %05b",
                                 $realtime, seen.read_data, seen[4:0]);
                end else begin
                    want = port_replies_q.pop_front();
                    if (seen !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("%0t: mismatch read_data %02h/%02h (expected/actual)",
                                     $realtime, want.read_data, seen.read_data);
                            $display("    busy r/c %b%b/%b%b ack r/c %b%b/%b%b latch %b/%b",
                                     want.busy_irq_raise, want.busy_irq_clear,
                                     seen.busy_irq_raise, seen.busy_irq_clear,
                                     want.ack_irq_raise, want.ack_irq_clear,
                                     seen.ack_irq_raise, seen.ack_irq_clear,
                                     want.latch_irq_raise, seen.latch_irq_raise);
                        end
                    end
                end
            end

            // input transfer: predict its reply
            if (s_valid && s_ready)
                port_replies_q.push_back(service_port_access(
                    op_t'(s_mode), s_write_data,
                    s_pad0_x, s_pad0_y, s_pad0_buttons,
                    s_pad1_x, s_pad1_y, s_pad1_buttons));

            // register writes apply from the next access on
            if (cfg_we) begin
                case (cfg_index)
                    REG_ADAPTER_TYPE: adapter_sel = adapter_t'(cfg_data);
                    REG_SUPERIO_MODE: superio_sel = cfg_data[0];
                    default: ;
                endcase
            end

            replies_due <= port_replies_q.size();
        end
    end

endmodule

// ----- verif/tb_parallel_port_joypad_adapter_core.sv -----
module tb_parallel_port_joypad_adapter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import ppja_pkg::*;

    localparam int unsigned RANDOM_ITEMS   = 1400;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 8;

    // receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN     = 2'd0,
        RX_COIN     = 2'd1,
        RX_SPARSE   = 2'd2,
        RX_PERIODIC = 2'd3
    } stall_style_t;

    // one port access with the pad snapshot that rides along
    typedef struct {
        op_t                op;
        logic        [7:0]  data;
        logic signed [15:0] pad0_x;
        logic signed [15:0] pad0_y;
        logic        [7:0]  pad0_buttons;
        logic signed [15:0] pad1_x;
        logic signed [15:0] pad1_y;
        logic        [7:0]  pad1_buttons;
    } access_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               cfg_we;
    logic [0:0]         cfg_index;
    logic [1:0]         cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic [7:0]         s_write_data;
    logic signed [15:0] s_pad0_x;
    logic signed [15:0] s_pad0_y;
    logic [7:0]         s_pad0_buttons;
    logic signed [15:0] s_pad1_x;
    logic signed [15:0] s_pad1_y;
    logic [7:0]         s_pad1_buttons;
    logic               m_valid;
    logic               m_ready;
    logic [7:0]         m_read_data;
    logic               m_busy_irq_raise;
    logic               m_busy_irq_clear;
    logic               m_ack_irq_raise;
    logic               m_ack_irq_clear;
    logic               m_latch_irq_raise;

    int unsigned        mismatch_count;
    int unsigned        replies_due;
    int unsigned        items_sent  = 0;
    int unsigned        burst_left  = 0;
    int unsigned        quiet_cycles = 0;

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    parallel_port_joypad_adapter_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_write_data      (s_write_data),
        .s_pad0_x          (s_pad0_x),
        .s_pad0_y          (s_pad0_y),
        .s_pad0_buttons    (s_pad0_buttons),
        .s_pad1_x          (s_pad1_x),
        .s_pad1_y          (s_pad1_y),
        .s_pad1_buttons    (s_pad1_buttons),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_busy_irq_raise  (m_busy_irq_raise),
        .m_busy_irq_clear  (m_busy_irq_clear),
        .m_ack_irq_raise   (m_ack_irq_raise),
        .m_ack_irq_clear   (m_ack_irq_clear),
        .m_latch_irq_raise (m_latch_irq_raise)
    );

    ppja_port_monitor port_monitor (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_write_data      (s_write_data),
        .s_pad0_x          (s_pad0_x),
        .s_pad0_y          (s_pad0_y),
        .s_pad0_buttons    (s_pad0_buttons),
        .s_pad1_x          (s_pad1_x),
        .s_pad1_y          (s_pad1_y),
        .s_pad1_buttons    (s_pad1_buttons),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_data       (m_read_data),
        .m_busy_irq_raise  (m_busy_irq_raise),
        .m_busy_irq_clear  (m_busy_irq_clear),
        .m_ack_irq_raise   (m_ack_irq_raise),
        .m_ack_irq_clear   (m_ack_irq_clear),
        .m_latch_irq_raise (m_latch_irq_raise),
        .mismatch_count    (mismatch_count),
        .replies_due       (replies_due)
    );

    // axis values biased toward the thresholds and the rails
    function automatic logic signed [15:0] random_axis();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd16384;
            3: return -16'sd16383;
            4: return 16'sd16383;
            5: return 16'sd16384;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] random_buttons();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic access_t make_access(input op_t op, input logic [7:0] data);
        access_t a;
        a.op           = op;
        a.data         = data;
        a.pad0_x       = random_axis();
        a.pad0_y       = random_axis();
        a.pad0_buttons = random_buttons();
        a.pad1_x       = random_axis();
        a.pad1_y       = random_axis();
        a.pad1_buttons = random_buttons();
        return a;
    endfunction

    function automatic access_t random_access();
        return make_access(($urandom_range(0, 3) == 0) ? OP_STATUS_READ : OP_DATA_WRITE,
                           8'($urandom));
    endfunction

    // offer one access, hold until transfer, then maybe pause between bursts
    task automatic send_access(input access_t a);
        int unsigned gap;
        s_valid        <= 1'b1;
        s_mode         <= a.op;
        s_write_data   <= a.data;
        s_pad0_x       <= a.pad0_x;
        s_pad0_y       <= a.pad0_y;
        s_pad0_buttons <= a.pad0_buttons;
        s_pad1_x       <= a.pad1_x;
        s_pad1_y       <= a.pad1_y;
        s_pad1_buttons <= a.pad1_buttons;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (burst_left != 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_write(input logic [7:0] data);
        send_access(make_access(OP_DATA_WRITE, data));
    endtask

    task automatic send_read();
        send_access(make_access(OP_STATUS_READ, 8'($urandom)));
    endtask

    // stop offering and wait for every reply to drain
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (replies_due != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input adapter_t kind, input logic superio);
        settle();
        write_reg(REG_ADAPTER_TYPE, kind);
        write_reg(REG_SUPERIO_MODE, {1'b0, superio});
    endtask

    // shift adapter: mostly latch-and-clock frames, some noise
    task automatic shift_traffic(input int unsigned count);
        int unsigned stop;
        int unsigned clocks;
        logic [7:0]  base;
        stop = items_sent + count;
        while (items_sent < stop) begin
            if ($urandom_range(0, 9) == 0) begin
                send_access(random_access());
            end else begin
                base = 8'($urandom);
                send_write(base | 8'h06);
                send_write((base & ~8'h02) | 8'h04);
                clocks = $urandom_range(1, 13);
                repeat (clocks) begin
                    base    = 8'($urandom);
                    base[1] = ($urandom_range(0, 7) == 0);
                    base[2] = 1'b0;
                    send_write(base);
                    base[2] = 1'b1;
                    send_write(base);
                    if ($urandom_range(0, 5) == 0) send_read();
                end
            end
        end
    endtask

    // matrix adapter: select bit 5 mostly high so the other sources matter
    task automatic matrix_traffic(input int unsigned count);
        logic [7:0] sel;
        repeat (count) begin
            if ($urandom_range(0, 4) == 0) begin
                send_read();
            end else begin
                sel = 8'($urandom);
                if ($urandom_range(0, 3) != 0) sel[5] = 1'b1;
                send_write(sel);
            end
        end
    endtask

    task automatic run_directed();
        access_t a;
        int      k;
        // no adapter after reset
        send_write(8'hff);
        send_read();

        // shift adapter with the axes at the rails
        set_config(ADAPTER_SHIFT, 1'b0);
        a = make_access(OP_DATA_WRITE, 8'h06);
        a.pad0_x = 16'sh7fff;      a.pad0_y = 16'sh8000;     a.pad0_buttons = 8'hff;
        a.pad1_x = -16'sd16384;    a.pad1_y = 16'sd16384;    a.pad1_buttons = 8'ha5;
        send_access(a);
        // latch and clock on the same write
        a.data = 8'h00;
        send_access(a);
        send_write(8'h04);
        send_write(8'h00);
        // axes exactly at the threshold are not pushed
        a.data = 8'h06;
        a.pad0_x = 16'sd16383;     a.pad0_y = -16'sd16383;   a.pad0_buttons = 8'h00;
        a.pad1_x = -16'sd16383;    a.pad1_y = 16'sd16383;    a.pad1_buttons = 8'h5a;
        send_access(a);
        a.data = 8'h04;
        send_access(a);
        send_write(8'h00);
        send_read();

        // matrix adapter: each select bit low on its own, then none
        set_config(ADAPTER_MATRIX, 1'b0);
        a = make_access(OP_DATA_WRITE, 8'h7f);
        a.pad0_x = 16'sh7fff;      a.pad0_y = 16'sh8000;     a.pad0_buttons = 8'h01;
        a.pad1_x = 16'sh8000;      a.pad1_y = 16'sh7fff;     a.pad1_buttons = 8'h02;
        for (k = 0; k < 7; k++) begin
            a.data = 8'h7f & ~(8'h01 << k);
            send_access(a);
        end
        a.data = 8'hff;
        send_access(a);
        send_read();

        // super-I/O: latch interrupt, pending flag cleared by a status read
        set_config(ADAPTER_SHIFT, 1'b1);
        send_write(8'h06);
        send_write(8'h00);
        send_read();
        send_read();
        set_config(ADAPTER_MATRIX, 1'b1);
        send_write(8'h5f);
        send_read();

        // unused adapter code behaves as no adapter
        set_config(ADAPTER_UNUSED, 1'b0);
        send_write(8'h00);
        send_read();
    endtask

    // result side stalls, with a new random style after each span
    initial begin
        stall_style_t style;
        int unsigned  span;
        int unsigned  tick;
        tick = 0;
        m_ready <= 1'b0;
        forever begin
            style = stall_style_t'($urandom_range(0, 3));
            span  = $urandom_range(64, 320);
            repeat (span) begin
                @(posedge aclk);
                tick++;
                case (style)
                    RX_OPEN:     m_ready <= 1'b1;
                    RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   m_ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: m_ready <= ((tick % 24) >= 16);
                    default:     m_ready <= 1'b1;
                endcase
            end
        end
    end

    // end the run if transfers stop
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // stimulus and verdict
    initial begin
        adapter_t    kind;
        int unsigned start;
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_ADAPTER_TYPE;
        cfg_data       <= 2'd0;
        s_valid        <= 1'b0;
        s_mode         <= OP_DATA_WRITE;
        s_write_data   <= 8'h00;
        s_pad0_x       <= 16'sd0;
        s_pad0_y       <= 16'sd0;
        s_pad0_buttons <= 8'h00;
        s_pad1_x       <= 16'sd0;
        s_pad1_y       <= 16'sd0;
        s_pad1_buttons <= 8'h00;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        // random phases under random register settings
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:             kind = ADAPTER_NONE;
                1:             kind = ADAPTER_UNUSED;
                2, 3, 4, 5:    kind = ADAPTER_SHIFT;
                default:       kind = ADAPTER_MATRIX;
            endcase
            set_config(kind, 1'($urandom_range(0, 1)));
            case (kind)
                ADAPTER_SHIFT:  shift_traffic(160);
                ADAPTER_MATRIX: matrix_traffic(120);
                default:        repeat (24) send_access(random_access());
            endcase
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
